@@ design/assert_macros.svh @@
// assertion macros used by the checker file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// condition holds in the same cycle as the trigger
`define VD_ASSERT_SAME(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |-> (cond)) \
        else $error(msg);

// condition holds in the cycle after the trigger
`define VD_ASSERT_NEXT(label, clk, rst_n, trig, cond, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (trig) |=> (cond)) \
        else $error(msg);

`endif

@@ design/vd_pkg.sv @@
// shared widths, constants and control types of the vector distance block
package vd_pkg;

    localparam int ELEM_W  = 16;
    localparam int DIFF_W  = ELEM_W + 1;
    localparam int TERM_W  = 2 * ELEM_W + 1;
    localparam int PROD_W  = 2 * DIFF_W;
    localparam int SUM_W   = 42;
    localparam int DIST_W  = 26;
    localparam int ROOT_W  = SUM_W / 2;
    localparam int REM_W   = ROOT_W + 3;
    localparam int STEP_W  = 5;

    localparam logic [STEP_W-1:0] SQRT_LAST_STEP = STEP_W'(ROOT_W - 1);
    localparam logic [SUM_W-1:0]  SUM_MAX        = {SUM_W{1'b1}};
    localparam logic [DIST_W-1:0] DIST_MAX       = {DIST_W{1'b1}};

    localparam logic MODE_EUCLID    = 1'b0;
    localparam logic MODE_MANHATTAN = 1'b1;

    typedef struct packed {
        logic capture;
        logic form_term;
        logic accumulate;
        logic clear;
    } t_acc_ctrl;

    typedef struct packed {
        logic busy;
        logic done;
    } t_sqrt_stat;

endpackage

@@ design/vd_acc.sv @@
// difference, term and saturating accumulator datapath
module vd_acc (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  vd_pkg::t_acc_ctrl            i_ctrl,
    input  logic                         i_mode,
    input  logic [vd_pkg::ELEM_W-1:0]    i_x,
    input  logic [vd_pkg::ELEM_W-1:0]    i_y,
    output logic [vd_pkg::SUM_W-1:0]     o_sum,
    output logic                         o_sat
);

    logic signed [vd_pkg::DIFF_W-1:0] diff;
    logic        [vd_pkg::DIFF_W-1:0] absd;
    logic        [vd_pkg::PROD_W-1:0] prod;
    logic        [vd_pkg::TERM_W-1:0] n_term;
    logic        [vd_pkg::SUM_W:0]    sum_ext;

    logic [vd_pkg::DIFF_W-1:0] r_absd;
    logic                      r_mode;
    logic [vd_pkg::TERM_W-1:0] r_term;
    logic [vd_pkg::SUM_W-1:0]  r_sum;
    logic                      r_sat;

    assign diff = $signed({i_x[vd_pkg::ELEM_W-1], i_x}) - $signed({i_y[vd_pkg::ELEM_W-1], i_y});
    assign absd = diff[vd_pkg::DIFF_W-1] ? vd_pkg::DIFF_W'(-diff) : vd_pkg::DIFF_W'(diff);
    assign prod = vd_pkg::PROD_W'(r_absd) * vd_pkg::PROD_W'(r_absd);
    assign n_term = (r_mode == vd_pkg::MODE_MANHATTAN) ? vd_pkg::TERM_W'(r_absd)
                                                       : prod[vd_pkg::TERM_W-1:0];
    assign sum_ext = {1'b0, r_sum} + (vd_pkg::SUM_W + 1)'(r_term);

    always_ff @(posedge i_clk) begin
        if (i_ctrl.capture) begin
            r_absd <= absd;
            r_mode <= i_mode;
        end
        if (i_ctrl.form_term) begin
            r_term <= n_term;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (i_ctrl.clear) begin
            r_sum <= '0;
            r_sat <= 1'b0;
        end else if (i_ctrl.accumulate) begin
            if (sum_ext[vd_pkg::SUM_W]) begin
                r_sum <= vd_pkg::SUM_MAX;
                r_sat <= 1'b1;
            end else begin
                r_sum <= sum_ext[vd_pkg::SUM_W-1:0];
            end
        end
    end

    assign o_sum = r_sum;
    assign o_sat = r_sat;

endmodule

@@ design/vd_sqrt.sv @@
// iterative floor square root, one root bit per cycle
module vd_sqrt (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_start,
    input  logic [vd_pkg::SUM_W-1:0]    i_value,
    output vd_pkg::t_sqrt_stat          o_stat,
    output logic [vd_pkg::ROOT_W-1:0]   o_root
);

    logic [vd_pkg::SUM_W-1:0]  r_val;
    logic [vd_pkg::REM_W-1:0]  r_rem;
    logic [vd_pkg::ROOT_W-1:0] r_root;
    logic [vd_pkg::STEP_W-1:0] r_cnt;
    logic                      r_busy;
    logic                      r_done;

    logic [vd_pkg::REM_W-1:0] rem_sh;
    logic [vd_pkg::REM_W-1:0] trial;
    logic                     fits;

    assign rem_sh = {r_rem[vd_pkg::REM_W-3:0], r_val[vd_pkg::SUM_W-1 -: 2]};
    assign trial  = {1'b0, r_root, 2'b01};
    assign fits   = (rem_sh >= trial);

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_val  <= i_value;
            r_rem  <= '0;
            r_root <= '0;
        end else if (r_busy) begin
            r_val  <= {r_val[vd_pkg::SUM_W-3:0], 2'b00};
            r_rem  <= fits ? (rem_sh - trial) : rem_sh;
            r_root <= {r_root[vd_pkg::ROOT_W-2:0], fits};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= vd_pkg::SQRT_LAST_STEP;
            end else if (r_busy) begin
                if (r_cnt == '0) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end else begin
                    r_cnt <= r_cnt - 1'b1;
                end
            end
        end
    end

    assign o_stat.busy = r_busy;
    assign o_stat.done = r_done;
    assign o_root      = r_root;

endmodule

@@ design/vector_distance_core.sv @@
// vector distance top level: sequencer, mode register and result register
// One element pair is taken at a time, the next only after capture of |x-y|,
// forming the term (the square through the multiplier, or the absolute value
// itself) and the saturating 42-bit accumulate. On the last pair a Manhattan
// result is registered directly; a Euclidean result waits for the bit-serial
// square root unit, which produces one of its 21 root bits per cycle. While an
// item is in flight o_in_stall is high. The result register holds a finished
// distance until taken, so the next vector can already stream in; a final pair
// waits only if the previous result is still unclaimed.
module vector_distance_core (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_stall,
    input  logic [vd_pkg::ELEM_W-1:0]   i_x_element,
    input  logic [vd_pkg::ELEM_W-1:0]   i_y_element,
    input  logic                        i_last_element,
    output logic                        o_out_valid,
    input  logic                        i_out_stall,
    output logic [vd_pkg::DIST_W-1:0]   o_distance,
    output logic                        o_saturated,
    input  logic                        i_cfg_valid,
    output logic                        o_cfg_ready,
    input  logic                        i_cfg_data
);

    typedef enum logic [4:0] {
        S_IDLE = 5'b00001,
        S_TERM = 5'b00010,
        S_ADD  = 5'b00100,
        S_FIN  = 5'b01000,
        S_ROOT = 5'b10000
    } t_state;

    t_state r_state, n_state;

    logic                      r_distance_mode;
    logic                      r_item_last;
    logic                      r_item_mode;
    logic                      r_fin_sat;
    logic                      r_out_valid;
    logic [vd_pkg::DIST_W-1:0] r_distance;
    logic                      r_saturated;

    vd_pkg::t_acc_ctrl         acc_ctrl;
    vd_pkg::t_sqrt_stat        sqrt_stat;
    logic [vd_pkg::SUM_W-1:0]  sum;
    logic                      sum_sat;
    logic [vd_pkg::ROOT_W-1:0] root;
    logic                      in_take;
    logic                      out_free;
    logic                      fin_go;
    logic                      sqrt_start;
    logic                      man_over;

    assign in_take  = i_in_valid && !o_in_stall;
    assign out_free = !r_out_valid || !i_out_stall;
    assign fin_go   = (r_state == S_FIN) && !r_out_valid;
    assign man_over = |sum[vd_pkg::SUM_W-1:vd_pkg::DIST_W];

    assign sqrt_start          = fin_go && (r_item_mode == vd_pkg::MODE_EUCLID);
    assign acc_ctrl.capture    = in_take;
    assign acc_ctrl.form_term  = (r_state == S_TERM);
    assign acc_ctrl.accumulate = (r_state == S_ADD);
    assign acc_ctrl.clear      = fin_go;

    vd_acc u_acc (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctrl  (acc_ctrl),
        .i_mode  (r_distance_mode),
        .i_x     (i_x_element),
        .i_y     (i_y_element),
        .o_sum   (sum),
        .o_sat   (sum_sat)
    );

    vd_sqrt u_sqrt (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (sqrt_start),
        .i_value (sum),
        .o_stat  (sqrt_stat),
        .o_root  (root)
    );

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_IDLE: begin
                if (in_take) n_state = S_TERM;
            end
            S_TERM: n_state = S_ADD;
            S_ADD: begin
                n_state = r_item_last ? S_FIN : S_IDLE;
            end
            S_FIN: begin
                if (fin_go) begin
                    n_state = (r_item_mode == vd_pkg::MODE_EUCLID) ? S_ROOT : S_IDLE;
                end
            end
            S_ROOT: begin
                if (sqrt_stat.done) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state         <= S_IDLE;
            r_distance_mode <= vd_pkg::MODE_EUCLID;
            r_out_valid     <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                r_distance_mode <= i_cfg_data;
            end
            if ((fin_go && r_item_mode == vd_pkg::MODE_MANHATTAN) ||
                (r_state == S_ROOT && sqrt_stat.done)) begin
                r_out_valid <= 1'b1;
            end else if (out_free) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_item_last <= i_last_element;
            r_item_mode <= r_distance_mode;
        end
        if (fin_go) begin
            r_fin_sat <= sum_sat;
            if (r_item_mode == vd_pkg::MODE_MANHATTAN) begin
                r_distance  <= man_over ? vd_pkg::DIST_MAX : sum[vd_pkg::DIST_W-1:0];
                r_saturated <= sum_sat || man_over;
            end
        end
        if (r_state == S_ROOT && sqrt_stat.done) begin
            r_distance  <= vd_pkg::DIST_W'(root);
            r_saturated <= r_fin_sat;
        end
    end

    assign o_in_stall  = (r_state != S_IDLE);
    assign o_out_valid = r_out_valid;
    assign o_distance  = r_distance;
    assign o_saturated = r_saturated;
    assign o_cfg_ready = 1'b1;

endmodule

@@ design/vd_checker.sv @@
// port-level checker for the vector distance block, bound to the top level
`include "assert_macros.svh"

module vd_checker (
    input logic                        i_clk,
    input logic                        i_rst_n,
    input logic                        i_in_valid,
    input logic                        o_in_stall,
    input logic                        i_last_element,
    input logic                        o_out_valid,
    input logic                        i_out_stall,
    input logic [vd_pkg::DIST_W-1:0]   o_distance,
    input logic                        o_saturated,
    input logic                        i_cfg_valid,
    input logic                        o_cfg_ready
);

    logic in_take;

    assign in_take = i_in_valid && !o_in_stall;

    // held result stays put
    `VD_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, o_out_valid && i_out_stall,
        o_out_valid && $stable(o_distance) && $stable(o_saturated),
        "result changed while stalled")

    // a request keeps the block busy on the next cycle
    `VD_ASSERT_NEXT(a_busy_after_take, i_clk, i_rst_n, in_take, o_in_stall,
        "block took a request back to back")

    // a pair that is not last never produces a result straight away
    `VD_ASSERT_NEXT(a_no_early_result, i_clk, i_rst_n, in_take && !i_last_element,
        !$rose(o_out_valid), "result without a last pair")

    // mode register always writable
    `VD_ASSERT_SAME(a_cfg_ready, i_clk, i_rst_n, i_cfg_valid, o_cfg_ready,
        "configuration write refused")

endmodule

bind vector_distance_core vd_checker u_vd_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_in_valid     (i_in_valid),
    .o_in_stall     (o_in_stall),
    .i_last_element (i_last_element),
    .o_out_valid    (o_out_valid),
    .i_out_stall    (i_out_stall),
    .o_distance     (o_distance),
    .o_saturated    (o_saturated),
    .i_cfg_valid    (i_cfg_valid),
    .o_cfg_ready    (o_cfg_ready)
);
